// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- design/sgssc_pkg.sv -----
// ----------------------------------------------------------------------------
// Standby generator start/stop control package
// Configuration layout, register indexes, result codes and fixed tick values.
// ----------------------------------------------------------------------------
package sgssc_pkg;

  localparam logic [31:0] TICK_MAX              = 32'hFFFF_FFFF;
  localparam logic [31:0] START_GUARD_TICKS     = 32'd15;
  localparam logic [31:0] STOP_RESTART_TICK     = 32'd20;
  localparam logic [31:0] EXERCISE_RESTART_TICK = 32'd21;
  localparam logic [3:0]  ATTEMPT_CAP           = 4'd14;

  localparam logic [31:0] RST_EXERCISE_START = 32'd604800;
  localparam logic [31:0] RST_EXERCISE_END   = 32'd606000;
  localparam logic [14:0] RST_RUN_DEBOUNCE   = 15'd5;
  localparam logic [14:0] RST_REQ_DEBOUNCE   = 15'd5;
  localparam logic [15:0] RST_COOLDOWN       = 16'd300;
  localparam logic [15:0] RST_RESTART_GAP    = 16'd60;
  localparam logic [3:0]  RST_ATTEMPT_LIMIT  = 4'd2;

  typedef enum logic [2:0] {
    REG_EXERCISE_START = 3'd0,
    REG_EXERCISE_END   = 3'd1,
    REG_RUN_DEBOUNCE   = 3'd2,
    REG_REQ_DEBOUNCE   = 3'd3,
    REG_COOLDOWN       = 3'd4,
    REG_RESTART_GAP    = 3'd5,
    REG_ATTEMPT_LIMIT  = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    RELAY_NONE  = 2'd0,
    RELAY_START = 2'd1,
    RELAY_STOP  = 2'd2
  } relay_t;

  typedef enum logic [2:0] {
    REQ_EV_NONE           = 3'd0,
    REQ_EV_EXERCISE_START = 3'd1,
    REQ_EV_EXERCISE_END   = 3'd2,
    REQ_EV_POWER_FAIL     = 3'd3,
    REQ_EV_POWER_RESTORED = 3'd4
  } req_event_t;

  // The attempt limit is held already clamped to the cap.
  typedef struct packed {
    logic [31:0] exercise_start_tick;
    logic [31:0] exercise_end_tick;
    logic [14:0] running_debounce;
    logic [14:0] request_debounce;
    logic [15:0] cooldown_length;
    logic [15:0] restart_gap;
    logic [3:0]  attempt_limit;
  } cfg_t;

endpackage

// ----- design/standby_generator_start_stop_control_core.sv -----
// ----------------------------------------------------------------------------
// Standby generator start/stop control core
// Debounces the generator and power request, runs the exercise window and
// commands start and stop pulses, one control tick per request.
// ----------------------------------------------------------------------------
// One tick request is taken in every clock cycle and its result appears in the
// output register on the following cycle. The whole tick update is a single
// pass of logic from the controller state to that register, so the input
// stalls only while the output register holds a result that has not been
// taken. Configuration writes are always accepted and take effect on the next
// cycle; they are meant to be made while no tick is in flight.
module standby_generator_start_stop_control_core
  import sgssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        exerciser_selected,
  input  logic        running_sense,
  input  logic        line_failed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  relay_command,
  output logic        running_event,
  output logic [2:0]  request_event,
  output logic        start_failed_event,
  output logic        failure_mode,
  output logic        led_cooldown,
  output logic        led_running,
  output logic        led_request,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "assert_macros.svh"

  cfg_t cfg;

  logic [31:0] tick_count, tick_count_next;
  logic        exerciser_on, exerciser_on_next;
  logic        gen_running, gen_running_next;
  logic [15:0] running_stable_count, running_stable_count_next;
  logic        power_requested, power_requested_next;
  logic [14:0] request_stable_count, request_stable_count_next;
  logic        forced_exercise, forced_exercise_next;
  logic        started_by_exercise, started_by_exercise_next;
  logic [15:0] cooldown_count, cooldown_count_next;
  logic [15:0] start_wait_count, start_wait_count_next;
  logic [3:0]  attempt_count, attempt_count_next;
  logic [2:0]  led_levels, led_levels_next;

  logic        in_fire;
  logic        locked;
  logic        req_now;
  logic [15:0] cooldown_inc;
  logic [15:0] wait_inc;
  logic [3:0]  attempt_step;

  relay_t      relay_next;
  req_event_t  req_event_next;
  logic        run_event_next;
  logic        fail_event_next;
  logic        failure_mode_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign locked    = attempt_count > cfg.attempt_limit;

  sgssc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_comb begin
    exerciser_on_next         = exerciser_on;
    gen_running_next          = gen_running;
    running_stable_count_next = running_stable_count;
    power_requested_next      = power_requested;
    request_stable_count_next = request_stable_count;
    forced_exercise_next      = forced_exercise;
    started_by_exercise_next  = started_by_exercise;
    cooldown_count_next       = cooldown_count;
    start_wait_count_next     = start_wait_count;
    attempt_count_next        = attempt_count;
    led_levels_next           = led_levels;
    relay_next                = RELAY_NONE;
    req_event_next            = REQ_EV_NONE;
    run_event_next            = 1'b0;
    fail_event_next           = 1'b0;
    failure_mode_next         = 1'b0;
    req_now                   = line_failed || forced_exercise;
    cooldown_inc              = cooldown_count + 16'd1;
    wait_inc                  = start_wait_count + 16'd1;
    attempt_step              = attempt_count;

    tick_count_next = (tick_count == TICK_MAX) ? tick_count : tick_count + 32'd1;

    if (locked) begin
      led_levels_next   = '0;
      failure_mode_next = 1'b1;
    end else begin
      if (!exerciser_on && exerciser_selected) begin
        tick_count_next = EXERCISE_RESTART_TICK;
      end
      exerciser_on_next = exerciser_selected;

      if (running_sense != gen_running) begin
        if (running_stable_count > {1'b0, cfg.running_debounce}) begin
          gen_running_next = running_sense;
          if (running_sense) begin
            run_event_next = 1'b1;
          end else if (!power_requested) begin
            tick_count_next = STOP_RESTART_TICK;
          end
          running_stable_count_next = '0;
        end else begin
          running_stable_count_next = running_stable_count + 16'd1;
        end
      end else begin
        running_stable_count_next = '0;
      end

      if (req_now != power_requested) begin
        if (request_stable_count >= cfg.request_debounce) begin
          power_requested_next = req_now;
          if (forced_exercise || started_by_exercise) begin
            req_event_next           = req_now ? REQ_EV_EXERCISE_START : REQ_EV_EXERCISE_END;
            started_by_exercise_next = req_now;
          end else begin
            req_event_next = req_now ? REQ_EV_POWER_FAIL : REQ_EV_POWER_RESTORED;
          end
          request_stable_count_next = '0;
        end else begin
          request_stable_count_next = request_stable_count + 15'd1;
        end
      end else begin
        request_stable_count_next = '0;
      end

      led_levels_next[0] = (cooldown_count != '0) ? ~led_levels[0] : 1'b0;
      led_levels_next[1] = (running_stable_count_next != '0) ? ~led_levels[1]
                                                             : gen_running_next;
      led_levels_next[2] = (request_stable_count_next != '0) ? ~led_levels[2]
                                                             : power_requested_next;

      forced_exercise_next = exerciser_on_next &&
                             (tick_count_next >= cfg.exercise_start_tick) &&
                             (tick_count_next <= cfg.exercise_end_tick);

      if (gen_running_next) begin
        start_wait_count_next = '0;
        attempt_count_next    = '0;
        if (power_requested_next) begin
          cooldown_count_next = '0;
        end else if (cooldown_inc >= cfg.cooldown_length) begin
          relay_next          = RELAY_STOP;
          cooldown_count_next = '0;
        end else begin
          cooldown_count_next = cooldown_inc;
        end
      end else begin
        cooldown_count_next = '0;
        if (power_requested_next && (tick_count_next > START_GUARD_TICKS)) begin
          if (start_wait_count == '0) begin
            relay_next   = RELAY_START;
            attempt_step = attempt_count + 4'd1;
          end
          start_wait_count_next = wait_inc;
          attempt_count_next    = attempt_step;
          if ((wait_inc > cfg.restart_gap) && (attempt_step <= cfg.attempt_limit)) begin
            if (attempt_step == cfg.attempt_limit) begin
              fail_event_next    = 1'b1;
              attempt_count_next = attempt_step + 4'd1;
            end else begin
              start_wait_count_next = '0;
            end
          end
        end else begin
          start_wait_count_next = '0;
          attempt_count_next    = '0;
        end
      end

      failure_mode_next = attempt_count_next > cfg.attempt_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count           <= '0;
      exerciser_on         <= 1'b0;
      gen_running          <= 1'b0;
      running_stable_count <= '0;
      power_requested      <= 1'b0;
      request_stable_count <= '0;
      forced_exercise      <= 1'b0;
      started_by_exercise  <= 1'b0;
      cooldown_count       <= '0;
      start_wait_count     <= '0;
      attempt_count        <= '0;
      led_levels           <= '0;
    end else if (in_fire) begin
      tick_count           <= tick_count_next;
      exerciser_on         <= exerciser_on_next;
      gen_running          <= gen_running_next;
      running_stable_count <= running_stable_count_next;
      power_requested      <= power_requested_next;
      request_stable_count <= request_stable_count_next;
      forced_exercise      <= forced_exercise_next;
      started_by_exercise  <= started_by_exercise_next;
      cooldown_count       <= cooldown_count_next;
      start_wait_count     <= start_wait_count_next;
      attempt_count        <= attempt_count_next;
      led_levels           <= led_levels_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      relay_command      <= relay_next;
      running_event      <= run_event_next;
      request_event      <= req_event_next;
      start_failed_event <= fail_event_next;
      failure_mode       <= failure_mode_next;
      led_cooldown       <= led_levels_next[0];
      led_running        <= led_levels_next[1];
      led_request        <= led_levels_next[2];
    end
  end

  `ASSERT_CLK(a_lock_holds, (locked && !cfg_valid) |=> locked, "Failure lock released without a configuration write")
  `ASSERT_NEVER(a_fail_ev_mode, out_valid && start_failed_event && !failure_mode, "Start failure reported outside failure mode")
  `ASSERT_NEVER(a_start_running, out_valid && (relay_command == RELAY_START) && gen_running, "Start pulse commanded while the generator is running")
  `ASSERT_CLK(a_locked_quiet, (in_fire && locked) |=> (relay_command == RELAY_NONE) && failure_mode, "Locked tick produced a relay command")

endmodule

// ----- design/sgssc_cfg.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Decodes register writes and holds the settings, clamping the attempt limit.
// ----------------------------------------------------------------------------
module sgssc_cfg
  import sgssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        REG_EXERCISE_START: cfg_next.exercise_start_tick = cfg_data;
        REG_EXERCISE_END:   cfg_next.exercise_end_tick   = cfg_data;
        REG_RUN_DEBOUNCE:   cfg_next.running_debounce    = cfg_data[14:0];
        REG_REQ_DEBOUNCE:   cfg_next.request_debounce    = cfg_data[14:0];
        REG_COOLDOWN:       cfg_next.cooldown_length     = cfg_data[15:0];
        REG_RESTART_GAP:    cfg_next.restart_gap         = cfg_data[15:0];
        REG_ATTEMPT_LIMIT: begin
          cfg_next.attempt_limit = (cfg_data[3:0] > ATTEMPT_CAP) ? ATTEMPT_CAP : cfg_data[3:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exercise_start_tick <= RST_EXERCISE_START;
      cfg.exercise_end_tick   <= RST_EXERCISE_END;
      cfg.running_debounce    <= RST_RUN_DEBOUNCE;
      cfg.request_debounce    <= RST_REQ_DEBOUNCE;
      cfg.cooldown_length     <= RST_COOLDOWN;
      cfg.restart_gap         <= RST_RESTART_GAP;
      cfg.attempt_limit       <= RST_ATTEMPT_LIMIT;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ----- tb/standby_tick_checker.sv -----
// ----------------------------------------------------------------------------
// Standby generator tick checker
// Watches the tick, result and register channels of the start/stop control
// core. It keeps its own copy of the controller state and registers, works out
// the result of every accepted tick request and compares each result that is
// taken, field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
module standby_tick_checker
  import sgssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        exerciser_selected,
  input  logic        running_sense,
  input  logic        line_failed,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  relay_command,
  input  logic        running_event,
  input  logic [2:0]  request_event,
  input  logic        start_failed_event,
  input  logic        failure_mode,
  input  logic        led_cooldown,
  input  logic        led_running,
  input  logic        led_request,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    relay_t     relay;
    logic       running_ev;
    req_event_t request_ev;
    logic       start_fail_ev;
    logic       fail_mode;
    logic       lamp_cool;
    logic       lamp_run;
    logic       lamp_req;
  } tick_result_t;

  logic [31:0] win_open;
  logic [31:0] win_close;
  logic [14:0] run_db;
  logic [14:0] req_db;
  logic [15:0] cool_len;
  logic [15:0] retry_gap;
  logic [3:0]  attempt_lim;

  logic [31:0] tick_cnt;
  logic        exer_on;
  logic        gen_on;
  logic [15:0] run_settle;
  logic        pwr_req;
  logic [15:0] req_settle;
  logic        exer_forced;
  logic        exer_started;
  logic [15:0] cool_cnt;
  logic [15:0] retry_wait;
  logic [3:0]  attempts;
  logic [2:0]  leds;

  tick_result_t awaited_q[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic clear_controller();
    win_open     = RST_EXERCISE_START;
    win_close    = RST_EXERCISE_END;
    run_db       = RST_RUN_DEBOUNCE;
    req_db       = RST_REQ_DEBOUNCE;
    cool_len     = RST_COOLDOWN;
    retry_gap    = RST_RESTART_GAP;
    attempt_lim  = RST_ATTEMPT_LIMIT;
    tick_cnt     = '0;
    exer_on      = 1'b0;
    gen_on       = 1'b0;
    run_settle   = '0;
    pwr_req      = 1'b0;
    req_settle   = '0;
    exer_forced  = 1'b0;
    exer_started = 1'b0;
    cool_cnt     = '0;
    retry_wait   = '0;
    attempts     = '0;
    leds         = '0;
  endtask

  task automatic advance_tick(input logic sel, input logic run_now, input logic lf,
                              output tick_result_t res);
    logic [3:0] lim;
    logic       req_now;
    logic       blue;
    logic       yellow;
    logic       red;
    lim = (attempt_lim > ATTEMPT_CAP) ? ATTEMPT_CAP : attempt_lim;
    res = '0;
    if (tick_cnt != TICK_MAX) begin
      tick_cnt = tick_cnt + 32'd1;
    end
    if (attempts > lim) begin
      leds = '0;
      res.fail_mode = 1'b1;
    end else begin
      if (!exer_on && sel) begin
        tick_cnt = EXERCISE_RESTART_TICK;
      end
      exer_on = sel;

      if (run_now != gen_on) begin
        if (run_settle > run_db) begin
          gen_on = run_now;
          if (gen_on) begin
            res.running_ev = 1'b1;
          end else if (!pwr_req) begin
            tick_cnt = STOP_RESTART_TICK;
          end
          run_settle = '0;
        end else begin
          run_settle = run_settle + 16'd1;
        end
      end else begin
        run_settle = '0;
      end

      req_now = lf || exer_forced;
      if (req_now != pwr_req) begin
        if (req_settle >= req_db) begin
          pwr_req = req_now;
          if (exer_forced || exer_started) begin
            res.request_ev = pwr_req ? REQ_EV_EXERCISE_START : REQ_EV_EXERCISE_END;
            exer_started = pwr_req;
          end else begin
            res.request_ev = pwr_req ? REQ_EV_POWER_FAIL : REQ_EV_POWER_RESTORED;
          end
          req_settle = '0;
        end else begin
          req_settle = req_settle + 16'd1;
        end
      end else begin
        req_settle = '0;
      end

      blue   = (cool_cnt != 0) ? ~leds[0] : 1'b0;
      yellow = (run_settle != 0) ? ~leds[1] : gen_on;
      red    = (req_settle != 0) ? ~leds[2] : pwr_req;
      leds   = {red, yellow, blue};

      exer_forced = exer_on && (tick_cnt >= win_open) && (tick_cnt <= win_close);

      if (gen_on) begin
        retry_wait = '0;
        attempts   = '0;
        if (pwr_req) begin
          cool_cnt = '0;
        end else begin
          cool_cnt = cool_cnt + 16'd1;
          if (cool_cnt >= cool_len) begin
            res.relay = RELAY_STOP;
            cool_cnt  = '0;
          end
        end
      end else begin
        cool_cnt = '0;
        if (pwr_req && (tick_cnt > START_GUARD_TICKS)) begin
          if (retry_wait == 0) begin
            res.relay = RELAY_START;
            attempts  = attempts + 4'd1;
          end
          retry_wait = retry_wait + 16'd1;
          if ((retry_wait > retry_gap) && (attempts <= lim)) begin
            if (attempts == lim) begin
              res.start_fail_ev = 1'b1;
              attempts = attempts + 4'd1;
            end else begin
              retry_wait = '0;
            end
          end
        end else begin
          retry_wait = '0;
          attempts   = '0;
        end
      end

      res.fail_mode = (attempts > lim);
      res.lamp_cool = leds[0];
      res.lamp_run  = leds[1];
      res.lamp_req  = leds[2];
    end
  endtask

  task automatic check_field(input string what, input logic [2:0] want, input logic [2:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches = mismatches + 1;
    end
  endtask

  always @(posedge clk) begin : watch
    tick_result_t want;
    tick_result_t fresh;
    if (rst) begin
      clear_controller();
      awaited_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result expected none, got relay_command %0d request_event %0d",
                   $time, relay_command, request_event);
          mismatches = mismatches + 1;
        end else begin
          want = awaited_q.pop_front();
          check_field("relay_command", want.relay, relay_command);
          check_field("running_event", want.running_ev, running_event);
          check_field("request_event", want.request_ev, request_event);
          check_field("start_failed_event", want.start_fail_ev, start_failed_event);
          check_field("failure_mode", want.fail_mode, failure_mode);
          check_field("led_cooldown", want.lamp_cool, led_cooldown);
          check_field("led_running", want.lamp_run, led_running);
          check_field("led_request", want.lamp_req, led_request);
        end
      end
      if (in_valid && in_ready) begin
        advance_tick(exerciser_selected, running_sense, line_failed, fresh);
        awaited_q.push_back(fresh);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXERCISE_START: win_open    = cfg_data;
          REG_EXERCISE_END:   win_close   = cfg_data;
          REG_RUN_DEBOUNCE:   run_db      = cfg_data[14:0];
          REG_REQ_DEBOUNCE:   req_db      = cfg_data[14:0];
          REG_COOLDOWN:       cool_len    = cfg_data[15:0];
          REG_RESTART_GAP:    retry_gap   = cfg_data[15:0];
          REG_ATTEMPT_LIMIT:  attempt_lim = cfg_data[3:0];
          default: ;
        endcase
      end
    end
    pending = awaited_q.size();
  end

endmodule

// ----- tb/tb_standby_generator_start_stop_control_core.sv -----
// ----------------------------------------------------------------------------
// Standby generator start/stop control testbench
// Drives tick requests drawn from a small generator and mains model, with
// bursty input, an irregular result stall pattern and register settings that
// range from the extremes to random ones. Lock into failure mode is provoked
// and released, and a final start failure is left in place. The checker
// beside the block reports mismatches.
// ----------------------------------------------------------------------------
module tb_standby_generator_start_stop_control_core;
  import sgssc_pkg::*;

  localparam logic [2:0] REG_SPARE   = 3'd7;
  localparam int         HOLD_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        exerciser_selected;
  logic        running_sense;
  logic        line_failed;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  relay_command;
  logic        running_event;
  logic [2:0]  request_event;
  logic        start_failed_event;
  logic        failure_mode;
  logic        led_cooldown;
  logic        led_running;
  logic        led_request;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int mismatch_count;
  int pending_count;

  int items_sent   = 0;
  int results_seen = 0;
  int starts_seen  = 0;
  int stops_seen   = 0;
  int holds_asked  = 0;
  int burst_left   = 0;

  bit plant_on     = 1'b0;
  bit plant_dead   = 1'b0;
  bit quiet        = 1'b0;
  bit line_state   = 1'b0;
  bit exer_state   = 1'b0;
  int crank_left   = 0;
  int halt_left    = 0;
  int starts_done  = 0;
  int stops_done   = 0;

  standby_generator_start_stop_control_core u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .exerciser_selected (exerciser_selected),
    .running_sense      (running_sense),
    .line_failed        (line_failed),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .relay_command      (relay_command),
    .running_event      (running_event),
    .request_event      (request_event),
    .start_failed_event (start_failed_event),
    .failure_mode       (failure_mode),
    .led_cooldown       (led_cooldown),
    .led_running        (led_running),
    .led_request        (led_request),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  standby_tick_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .exerciser_selected (exerciser_selected),
    .running_sense      (running_sense),
    .line_failed        (line_failed),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .relay_command      (relay_command),
    .running_event      (running_event),
    .request_event      (request_event),
    .start_failed_event (start_failed_event),
    .failure_mode       (failure_mode),
    .led_cooldown       (led_cooldown),
    .led_running        (led_running),
    .led_request        (led_request),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatch_count),
    .pending            (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen = results_seen + 1;
      if (relay_command == RELAY_START) begin
        starts_seen = starts_seen + 1;
      end
      if (relay_command == RELAY_STOP) begin
        stops_seen = stops_seen + 1;
      end
    end
  end

  initial begin : receiver
    int mode;
    int span;
    int holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(5, 60);
      repeat (span) begin
        if (holds_done != holds_asked) begin
          holds_done = holds_asked;
          out_ready  = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0:       out_ready = 1'b1;
          1:       out_ready = 1'($urandom_range(0, 1));
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  task automatic send_tick(input logic ex, input logic run, input logic lf);
    int gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      case ($urandom_range(0, 5))
        0:       gap_len = 0;
        1:       gap_len = $urandom_range(4, 12);
        default: gap_len = $urandom_range(1, 3);
      endcase
      if (gap_len > 0) begin
        in_valid = 1'b0;
        repeat (gap_len) @(negedge clk);
      end
    end
    if (burst_left > 0) begin
      burst_left = burst_left - 1;
    end
    exerciser_selected = ex;
    running_sense      = run;
    line_failed        = lf;
    in_valid           = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent = items_sent + 1;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (results_seen < items_sent) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_all(input logic [31:0] open_tick, input logic [31:0] close_tick,
                         input logic [31:0] run_db, input logic [31:0] req_db,
                         input logic [31:0] cool, input logic [31:0] gap,
                         input logic [31:0] lim);
    drain();
    write_reg(REG_EXERCISE_START, open_tick);
    write_reg(REG_EXERCISE_END, close_tick);
    write_reg(REG_RUN_DEBOUNCE, run_db);
    write_reg(REG_REQ_DEBOUNCE, req_db);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_RESTART_GAP, gap);
    write_reg(REG_ATTEMPT_LIMIT, lim);
    cfg_valid = 1'b0;
  endtask

  // The generator answers start and stop pulses after a short delay, now and
  // then stalls or starts by itself, and its sense line glitches for a tick.
  task automatic random_ticks(input int count);
    logic run;
    logic lf;
    logic ex;
    for (int k = 0; k < count; k++) begin
      if (k == 10) begin
        holds_asked = holds_asked + 1;
      end
      if (starts_seen != starts_done) begin
        starts_done = starts_seen;
        if (!plant_dead && !plant_on && crank_left == 0) begin
          crank_left = $urandom_range(1, 4);
        end
      end
      if (stops_seen != stops_done) begin
        stops_done = stops_seen;
        if (!plant_dead && plant_on && halt_left == 0) begin
          halt_left = $urandom_range(1, 4);
        end
      end
      if (crank_left > 0) begin
        crank_left = crank_left - 1;
        if (crank_left == 0) plant_on = 1'b1;
      end
      if (halt_left > 0) begin
        halt_left = halt_left - 1;
        if (halt_left == 0) plant_on = 1'b0;
      end
      if ($urandom_range(0, 59) == 0) plant_on = !plant_on;
      if ($urandom_range(0, 29) == 0) line_state = !line_state;
      if ($urandom_range(0, 39) == 0) exer_state = !exer_state;
      run = plant_dead ? 1'b0 : (plant_on ^ ($urandom_range(0, 24) == 0));
      lf  = quiet ? 1'b1 : (line_state ^ ($urandom_range(0, 29) == 0));
      ex  = quiet ? 1'b0 : exer_state;
      send_tick(ex, run, lf);
    end
  endtask

  initial begin : stimulus
    logic [31:0] open_tick;
    rst                = 1'b1;
    in_valid           = 1'b0;
    exerciser_selected = 1'b0;
    running_sense      = 1'b0;
    line_failed        = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = REG_EXERCISE_START;
    cfg_data           = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < 24; i++) begin
      send_tick((i >= 6 && i < 10) || i >= 18, (i >= 12 && i < 15) || i == 20,
                (i >= 1 && i < 16) || i == 22);
    end

    drain();
    write_reg(REG_SPARE, 32'h5A5A_0003);
    set_all(32'd30, 32'd90, 32'd1, 32'd2, 32'd8, 32'd12, 32'd4);
    random_ticks(55);
    set_all(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1, 32'd0, 32'd15);
    random_ticks(55);
    set_all(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'd65534, 32'hFFFF_FFF1);
    random_ticks(30);
    set_all(32'd21, 32'd40, 32'd1, 32'd1, 32'd0, 32'd20, 32'd6);
    random_ticks(55);
    for (int p = 0; p < 4; p++) begin
      open_tick = $urandom_range(21, 80);
      set_all(open_tick, open_tick + $urandom_range(0, 60), $urandom_range(0, 4),
              $urandom_range(0, 4), $urandom_range(1, 25), $urandom_range(6, 30),
              $urandom_range(3, 14));
      random_ticks(20);
    end

    // With an attempt limit of zero the first start pulse locks the block;
    // raising the limit again releases it.
    plant_dead = 1'b1;
    quiet      = 1'b1;
    set_all(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd5, 32'd3, 32'd0);
    random_ticks(16);
    drain();
    write_reg(REG_ATTEMPT_LIMIT, 32'd14);
    cfg_valid  = 1'b0;
    plant_dead = 1'b0;
    random_ticks(20);

    plant_dead = 1'b1;
    set_all(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd5, 32'd3, 32'd2);
    random_ticks(24);
    drain();
    write_reg(REG_ATTEMPT_LIMIT, 32'd14);
    cfg_valid  = 1'b0;
    plant_dead = 1'b0;
    quiet      = 1'b0;
    random_ticks(40);

    plant_dead = 1'b1;
    quiet      = 1'b1;
    set_all(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd5, 32'd1, 32'd14);
    random_ticks(50);

    drain();
    repeat (5) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/sgssc_pkg.sv
design/sgssc_cfg.sv
design/standby_generator_start_stop_control_core.sv
tb/standby_tick_checker.sv
tb/tb_standby_generator_start_stop_control_core.sv
